/* hw/rtl/owdm_pkg.sv */
`default_nettype none
package owdm_pkg;

	localparam int unsigned HalfPiQ30 = 1686629713;

	typedef enum logic [1:0] {
		REG_MAX_DUTY    = 2'd0,
		REG_MIN_DUTY    = 2'd1,
		REG_KICK_OFFSET = 2'd2
	} reg_idx_t;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_MOD    = 12'b0000_0000_0010,
		S_RDS    = 12'b0000_0000_0100,
		S_MULY   = 12'b0000_0000_1000,
		S_MULX   = 12'b0000_0001_0000,
		S_MIX    = 12'b0000_0010_0000,
		S_MAX    = 12'b0000_0100_0000,
		S_DIV_LD = 12'b0000_1000_0000,
		S_DIV    = 12'b0001_0000_0000,
		S_DIV_WR = 12'b0010_0000_0000,
		S_DRIVE  = 12'b0100_0000_0000,
		S_DONE   = 12'b1000_0000_0000
	} state_t;

	// Unsigned long division by shift and subtract, evaluated only while building the table.
	function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
		longint unsigned quo;
		longint unsigned rem;
		quo = 0;
		rem = 0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], a[i]};
			quo = quo << 1;
			if (rem >= b) begin
				rem = rem - b;
				quo[0] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Sine of 2*pi*p/m in Q15, evaluated only while building the constant table.
	function automatic int sine_q15(longint unsigned p, longint unsigned m);
		longint unsigned t;
		longint unsigned q;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned s;
		int v;
		t = 4 * p;
		q = udiv(t, m);
		r = t - q * m;
		pos = 0;
		neg = 0;
		if (q[0])
			r = m - r;
		x = udiv(longint'(HalfPiQ30) * r, m);
		x2 = (x * x) >> 30;
		term = x;
		for (int n = 1; n <= 15; n += 2) begin
			if (term != 0) begin
				if (((n >> 1) & 1) == 0)
					pos = pos + term;
				else
					neg = neg + term;
				term = udiv((term * x2) >> 30, longint'((n + 1) * (n + 2)));
			end
		end
		s = (pos >= neg) ? (pos - neg) : 0;
		s = (s + 16384) >> 15;
		if (s > 32768)
			s = 32768;
		v = int'(s);
		return (q >= 2) ? -v : v;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/omni_wheel_drive_mixer_top.sv */
`default_nettype none
// Four-wheel X omni drive mixer: each transfer of (mode, speed, heading, turn_rate)
// yields one transfer of eight H-bridge pin duties, which are the held duties after
// the command. One shared 8x16 multiplier and one bit-serial divider run under a
// small sequencer, so the input is not ready while an item is in work. A coast
// command goes straight to the output; a move first reduces the heading by repeated
// subtraction of ANGLE_STEPS, and the wheel values are rescaled by four 8-step
// divisions when they exceed full duty. The result waits in an output
// register, so the next item can be accepted while it is pending.
module omni_wheel_drive_mixer_top #(
	parameter int ANGLE_STEPS = 360
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              mode,
	input  wire logic [7:0]        speed,
	input  wire logic [8:0]        heading,
	input  wire logic signed [8:0] turn_rate,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             wheel1_pin_a,
	output logic [7:0]             wheel1_pin_b,
	output logic [7:0]             wheel2_pin_a,
	output logic [7:0]             wheel2_pin_b,
	output logic [7:0]             wheel3_pin_a,
	output logic [7:0]             wheel3_pin_b,
	output logic [7:0]             wheel4_pin_a,
	output logic [7:0]             wheel4_pin_b
);

	localparam int HW = (ANGLE_STEPS > 1) ? $clog2(ANGLE_STEPS) : 1;
	localparam int CW = $clog2(ANGLE_STEPS + 1);
	localparam int MW = (CW > 9) ? CW : 9;
	localparam longint unsigned M8 = 8 * ANGLE_STEPS;

	owdm_pkg::state_t state_q;

	logic [7:0] max_duty_q;
	logic [7:0] min_duty_q;
	logic [7:0] kick_q;

	logic [7:0] held_q [8];
	logic [7:0] out_q [8];
	logic       ov_q;

	logic [MW-1:0]        hm_q;
	logic [7:0]           speed_q;
	logic signed [8:0]    turn_q;
	logic signed [16:0]   rom_q;
	logic signed [8:0]    y_q;
	logic signed [8:0]    x_q;
	logic signed [10:0]   w_q [4];
	logic [9:0]           max_q;
	logic [1:0]           widx_q;
	logic [2:0]           step_q;
	logic [9:0]           rem_q;
	logic [7:0]           dl_q;

	logic signed [16:0] sin_rom [ANGLE_STEPS];
	logic signed [16:0] cos_rom [ANGLE_STEPS];

	for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_rom
		localparam longint unsigned PS = (ANGLE_STEPS + M8 - 8 * g) % M8;
		localparam longint unsigned PC = (3 * ANGLE_STEPS + M8 - 8 * g) % M8;
		localparam int SV = owdm_pkg::sine_q15(PS, M8);
		localparam int CV = owdm_pkg::sine_q15(PC, M8);
		assign sin_rom[g] = 17'(SV);
		assign cos_rom[g] = 17'(CV);
	end

	// Shared multiplier: speed times the table magnitude, truncated toward zero.
	logic [16:0] rom_abs;
	logic [23:0] prod;
	logic [7:0]  pres;
	assign rom_abs = rom_q[16] ? 17'(-rom_q) : 17'(rom_q);
	assign prod    = speed_q * rom_abs[15:0];
	assign pres    = prod[22:15];

	logic signed [10:0] wraw [4];
	logic signed [10:0] wkick [4];
	logic [9:0]         wmag [4];
	always_comb begin
		wraw[0] = -11'(x_q) + 11'(turn_q);
		wraw[1] =  11'(y_q) + 11'(turn_q);
		wraw[2] =  11'(x_q) + 11'(turn_q);
		wraw[3] = -11'(y_q) + 11'(turn_q);
		for (int i = 0; i < 4; i++) begin
			if (wraw[i] > 0)
				wkick[i] = wraw[i] + 11'(kick_q);
			else if (wraw[i] < 0)
				wkick[i] = wraw[i] - 11'(kick_q);
			else
				wkick[i] = wraw[i];
			wmag[i] = w_q[i][10] ? 10'(-w_q[i]) : 10'(w_q[i]);
		end
	end

	logic [9:0] max_ab;
	logic [9:0] max_cd;
	assign max_ab = (wmag[0] > wmag[1]) ? wmag[0] : wmag[1];
	assign max_cd = (wmag[2] > wmag[3]) ? wmag[2] : wmag[3];

	logic [17:0] dvd;
	logic [10:0] dtry;
	logic        dge;
	logic [10:0] dsub;
	assign dvd  = {wmag[widx_q], 8'd0} - 18'(wmag[widx_q]);
	assign dtry = {rem_q, dl_q[7]};
	assign dge  = dtry >= {1'b0, max_q};
	assign dsub = dtry - {1'b0, max_q};

	assign in_ready = (state_q == owdm_pkg::S_IDLE);
	assign out_valid = ov_q;
	assign wheel1_pin_a = out_q[0];
	assign wheel1_pin_b = out_q[1];
	assign wheel2_pin_a = out_q[2];
	assign wheel2_pin_b = out_q[3];
	assign wheel3_pin_a = out_q[4];
	assign wheel3_pin_b = out_q[5];
	assign wheel4_pin_a = out_q[6];
	assign wheel4_pin_b = out_q[7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_duty_q <= 8'd255;
			min_duty_q <= 8'd0;
			kick_q     <= 8'd150;
		end else if (cfg_we) begin
			case (cfg_index)
				owdm_pkg::REG_MAX_DUTY:    max_duty_q <= cfg_data;
				owdm_pkg::REG_MIN_DUTY:    min_duty_q <= cfg_data;
				owdm_pkg::REG_KICK_OFFSET: kick_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Table read is registered; the cosine is fetched while the sine is multiplied.
	always_ff @(posedge clk) begin
		if (state_q == owdm_pkg::S_MULY)
			rom_q <= cos_rom[hm_q[HW-1:0]];
		else
			rom_q <= sin_rom[hm_q[HW-1:0]];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			owdm_pkg::S_IDLE: begin
				hm_q    <= MW'(heading);
				speed_q <= speed;
				turn_q  <= turn_rate;
			end
			owdm_pkg::S_MOD: begin
				if (hm_q >= MW'(ANGLE_STEPS))
					hm_q <= hm_q - MW'(ANGLE_STEPS);
			end
			owdm_pkg::S_MULY: y_q <= rom_q[16] ? -9'(pres) : 9'(pres);
			owdm_pkg::S_MULX: x_q <= rom_q[16] ? 9'(pres) : -9'(pres);
			owdm_pkg::S_MIX: begin
				for (int i = 0; i < 4; i++)
					w_q[i] <= wkick[i];
			end
			owdm_pkg::S_MAX: max_q <= (max_ab > max_cd) ? max_ab : max_cd;
			owdm_pkg::S_DIV_LD: begin
				rem_q <= dvd[17:8];
				dl_q  <= dvd[7:0];
			end
			owdm_pkg::S_DIV: begin
				rem_q <= dge ? dsub[9:0] : dtry[9:0];
				dl_q  <= {dl_q[6:0], dge};
			end
			owdm_pkg::S_DIV_WR: begin
				w_q[widx_q] <= w_q[widx_q][10] ? -11'(dl_q) : 11'(dl_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= owdm_pkg::S_IDLE;
			ov_q    <= 1'b0;
			widx_q  <= 2'd0;
			step_q  <= 3'd0;
			for (int i = 0; i < 8; i++) begin
				held_q[i] <= 8'd0;
				out_q[i]  <= 8'd0;
			end
		end else begin
			if (state_q == owdm_pkg::S_DONE && (!ov_q || out_ready))
				ov_q <= 1'b1;
			else if (ov_q && out_ready)
				ov_q <= 1'b0;
			case (state_q)
				owdm_pkg::S_IDLE: begin
					if (in_valid) begin
						if (mode) begin
							for (int i = 0; i < 8; i++)
								held_q[i] <= 8'd0;
							state_q <= owdm_pkg::S_DONE;
						end else begin
							state_q <= owdm_pkg::S_MOD;
						end
					end
				end
				owdm_pkg::S_MOD: begin
					if (hm_q < MW'(ANGLE_STEPS))
						state_q <= owdm_pkg::S_RDS;
				end
				owdm_pkg::S_RDS:  state_q <= owdm_pkg::S_MULY;
				owdm_pkg::S_MULY: state_q <= owdm_pkg::S_MULX;
				owdm_pkg::S_MULX: state_q <= owdm_pkg::S_MIX;
				owdm_pkg::S_MIX:  state_q <= owdm_pkg::S_MAX;
				owdm_pkg::S_MAX: begin
					widx_q  <= 2'd0;
					state_q <= owdm_pkg::S_DIV_LD;
				end
				owdm_pkg::S_DIV_LD: begin
					// Rescaling is needed only when some magnitude is above full duty.
					if (max_q > 10'd255) begin
						step_q  <= 3'd0;
						state_q <= owdm_pkg::S_DIV;
					end else begin
						state_q <= owdm_pkg::S_DRIVE;
					end
				end
				owdm_pkg::S_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7)
						state_q <= owdm_pkg::S_DIV_WR;
				end
				owdm_pkg::S_DIV_WR: begin
					widx_q <= widx_q + 2'd1;
					if (widx_q == 2'd3)
						state_q <= owdm_pkg::S_DRIVE;
					else
						state_q <= owdm_pkg::S_DIV_LD;
				end
				owdm_pkg::S_DRIVE: begin
					for (int i = 0; i < 4; i++) begin
						if (wmag[i] <= 10'(max_duty_q)) begin
							if (wmag[i] < 10'(min_duty_q)) begin
								held_q[2*i]   <= 8'd0;
								held_q[2*i+1] <= 8'd0;
							end else if (w_q[i][10]) begin
								held_q[2*i]   <= wmag[i][7:0];
								held_q[2*i+1] <= 8'd0;
							end else begin
								held_q[2*i]   <= 8'd0;
								held_q[2*i+1] <= wmag[i][7:0];
							end
						end
					end
					state_q <= owdm_pkg::S_DONE;
				end
				owdm_pkg::S_DONE: begin
					if (!ov_q || out_ready) begin
						for (int i = 0; i < 8; i++)
							out_q[i] <= held_q[i];
						state_q <= owdm_pkg::S_IDLE;
					end
				end
				default: state_q <= owdm_pkg::S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
